// ===== hw/rtl/sma_pkg.sv =====
// ============================================================================
// sma_pkg: shared types and constants of the servo move animator
// Field widths, table geometry, command codes and the controller/datapath
// command and status groups.
// ============================================================================
`default_nettype none

package sma_pkg;

    // Number of servo channels with a move table entry.
    localparam int NUM_CHANNELS = 16;

    // Field widths.
    localparam int CH_W    = 4;
    localparam int POS_W   = 12;
    localparam int STEPS_W = 16;
    localparam int IDX_W   = STEPS_W + 1;
    localparam int CATCH_W = 8;

    // Only channels that the channel field can address get a table entry.
    localparam int TBL_DEPTH = (NUM_CHANNELS < (2 ** CH_W)) ? NUM_CHANNELS : (2 ** CH_W);
    localparam int TBL_IDX_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // Register reset value.
    localparam logic [CATCH_W-1:0] CATCHUP_RESET = CATCH_W'(5);

    // Interpolation: |step * (end - start)| fits in STEPS_W + POS_W bits.
    localparam int PROD_W    = STEPS_W + POS_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Command codes of an input beat.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the accepted input beat
        logic eval;      // look up the channel, decide the step, load a start
        logic mul;       // form the interpolation product, arm the divider
        logic div_step;  // one restoring division step
        logic wb;        // write the table back and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;  // latched beat is a start command
        logic ch_ok;     // latched channel has a table entry
        logic interp;    // tick needs a new interpolated position
        logic div_last;  // divider is on its final step
        logic out_free;  // result register can take a new beat
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sma_if.sv =====
// ============================================================================
// sma_if: channel interfaces of the servo move animator
// Input item channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ============================================================================
`default_nettype none

interface sma_item_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [sma_pkg::CH_W-1:0]    channel;
    logic [sma_pkg::POS_W-1:0]   from_position;
    logic [sma_pkg::POS_W-1:0]   to_position;
    logic [sma_pkg::STEPS_W-1:0] step_count;
    logic                       use_alt_driver;

    modport source (
        output valid, command, channel, from_position, to_position, step_count,
               use_alt_driver,
        input  ready
    );
    modport sink (
        input  valid, command, channel, from_position, to_position, step_count,
               use_alt_driver,
        output ready
    );
endinterface

interface sma_result_if;
    logic                     valid;
    logic                     ready;
    logic [sma_pkg::CH_W-1:0]  out_channel;
    logic [sma_pkg::POS_W-1:0] position;
    logic                     write_strobe;
    logic                     alt_driver;
    logic                     active;

    modport source (
        output valid, out_channel, position, write_strobe, alt_driver, active,
        input  ready
    );
    modport sink (
        input  valid, out_channel, position, write_strobe, alt_driver, active,
        output ready
    );
endinterface

interface sma_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sma_pkg::CATCH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/servo_move_animator.sv =====
// ============================================================================
// servo_move_animator: per-channel servo move animator
// Start beats load a channel's move; tick beats step it and report the
// channel's position, write strobe, driver select and busy bit.
// ============================================================================
// Usage:
// An input beat on items carries a command, a channel and the move fields.
// A start beat loads the channel's move and gives no result; items.ready is
// high again once the table entry is loaded. A tick beat gives one result
// beat on results. A tick that steps the interpolation goes through lookup,
// a 16x12 multiply, a 28-step restoring divider and write-back; other ticks
// go from lookup straight to write-back, which loads the result register
// and returns to idle. Beats for channels without a table entry are dropped.
// One beat is worked on at a time; items.ready is high only between beats.
// The result register decouples the two sides: a new beat is accepted while
// a result still waits, and the write-back waits if the receiver stalls,
// which adds the stall to that beat's cycles.
// The cfg channel writes catchup_ticks and is always ready; write it only
// while the block is idle. Reset clears the move table (all channels idle)
// and sets catchup_ticks to 5.
// ============================================================================
`default_nettype none

module servo_move_animator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sma_item_if.sink      items,
    sma_result_if.source  results,
    sma_cfg_if.sink       cfg
);

    sma_pkg::ctrl_cmd_t  cmd;
    sma_pkg::dp_status_t status;
    logic                in_ready;

    assign items.ready = in_ready;
    assign cfg.ready   = 1'b1;

    // Sequencing controller.
    sma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Move table and arithmetic.
    sma_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_command   (items.command),
        .in_channel   (items.channel),
        .in_from      (items.from_position),
        .in_to        (items.to_position),
        .in_steps     (items.step_count),
        .in_alt       (items.use_alt_driver),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.data),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .out_channel  (results.out_channel),
        .out_position (results.position),
        .out_strobe   (results.write_strobe),
        .out_alt      (results.alt_driver),
        .out_active   (results.active)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sma_ctrl.sv =====
// ============================================================================
// sma_ctrl: sequencing controller of the servo move animator
// Walks one input beat through lookup and, where needed, multiply, division and write-back.
// ============================================================================
`default_nettype none

module sma_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sma_pkg::dp_status_t status,
    output sma_pkg::ctrl_cmd_t       cmd
);

    sma_pkg::state_t state_reg;
    sma_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sma_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            sma_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = sma_pkg::S_EVAL;
                end
            end
            sma_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.is_start || !status.ch_ok)
                begin
                    state_next = sma_pkg::S_IDLE;
                end
                else if (status.interp)
                begin
                    state_next = sma_pkg::S_MUL;
                end
                else
                begin
                    state_next = sma_pkg::S_WB;
                end
            end
            sma_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sma_pkg::S_DIV;
            end
            sma_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = sma_pkg::S_WB;
                end
            end
            sma_pkg::S_WB:
            begin
                if (status.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = sma_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sma_pkg::S_IDLE;
            end
        endcase
    end

    // The divider always follows the multiply.
    a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sma_pkg::S_MUL) |=> (state_reg == sma_pkg::S_DIV))
        else $error("multiply not followed by division");

    // A write-back with a free result register returns to idle.
    a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sma_pkg::S_WB && status.out_free) |=> (state_reg == sma_pkg::S_IDLE))
        else $error("write-back did not complete");

endmodule

`default_nettype wire

// ===== hw/rtl/sma_datapath.sv =====
// ============================================================================
// sma_datapath: move table and interpolation datapath
// Holds the per-channel move table, the catch-up register, the step
// decision, a 16x12 multiplier, a restoring divider and the result register.
// ============================================================================
`default_nettype none

module sma_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sma_pkg::ctrl_cmd_t            cmd,
    output sma_pkg::dp_status_t                status,
    // Input beat payload.
    input  wire logic                          in_command,
    input  wire logic [sma_pkg::CH_W-1:0]      in_channel,
    input  wire logic [sma_pkg::POS_W-1:0]     in_from,
    input  wire logic [sma_pkg::POS_W-1:0]     in_to,
    input  wire logic [sma_pkg::STEPS_W-1:0]   in_steps,
    input  wire logic                          in_alt,
    // Configuration write.
    input  wire logic                          cfg_we,
    input  wire logic [sma_pkg::CATCH_W-1:0]   cfg_data,
    // Result register.
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [sma_pkg::CH_W-1:0]           out_channel,
    output logic [sma_pkg::POS_W-1:0]          out_position,
    output logic                               out_strobe,
    output logic                               out_alt,
    output logic                               out_active
);

    localparam int PW = sma_pkg::POS_W;
    localparam int SW = sma_pkg::STEPS_W;
    localparam int IW = sma_pkg::IDX_W;

    // Move table.
    logic [SW-1:0] tot_reg  [sma_pkg::TBL_DEPTH];
    logic [IW-1:0] idx_reg  [sma_pkg::TBL_DEPTH];
    logic [PW-1:0] spos_reg [sma_pkg::TBL_DEPTH];
    logic [PW-1:0] epos_reg [sma_pkg::TBL_DEPTH];
    logic [PW-1:0] cpos_reg [sma_pkg::TBL_DEPTH];
    logic          alt_reg  [sma_pkg::TBL_DEPTH];

    logic [sma_pkg::CATCH_W-1:0] catchup_reg;

    // Latched input beat.
    logic                       item_cmd_reg;
    logic [sma_pkg::CH_W-1:0]   item_ch_reg;
    logic [PW-1:0]              item_from_reg;
    logic [PW-1:0]              item_to_reg;
    logic [SW-1:0]              item_steps_reg;
    logic                       item_alt_reg;

    // Step decision results.
    logic [IW-1:0]              ev_step_reg;
    logic                       ev_strobe_reg;
    logic                       ev_act_reg;
    logic                       ev_clear_reg;
    logic                       ev_neg_reg;
    logic [PW-1:0]              ev_mag_reg;
    logic [SW-1:0]              ev_n_reg;

    // Divider.
    logic [sma_pkg::PROD_W-1:0] dvd_reg;
    logic [SW-1:0]              rem_reg;
    logic [sma_pkg::CNT_W-1:0]  cnt_reg;

    // Result register.
    logic                       out_valid_reg;
    logic [sma_pkg::CH_W-1:0]   out_ch_reg;
    logic [PW-1:0]              out_pos_reg;
    logic                       out_strobe_reg;
    logic                       out_alt_reg;
    logic                       out_active_reg;

    logic [sma_pkg::TBL_IDX_W-1:0] tidx;
    logic                       ch_ok;
    logic [SW-1:0]              e_n;
    logic [IW-1:0]              e_idx;
    logic [PW-1:0]              e_spos;
    logic [PW-1:0]              e_epos;
    logic [PW-1:0]              e_cpos;
    logic                       e_alt;
    logic                       idle;
    logic [IW-1:0]              si0;
    logic [IW-1:0]              hold;
    logic                       interp;
    logic                       catchup;
    logic                       finish;
    logic [PW:0]                diff;
    logic [PW-1:0]              diff_mag;
    logic [sma_pkg::PROD_W-1:0] product;
    logic [SW:0]                trial_rem;
    logic [SW:0]                trial_sub;
    logic [PW-1:0]              quot;
    logic [PW-1:0]              pos_new;
    logic                       out_free;

    // Table entry of the latched channel.
    assign tidx   = item_ch_reg[sma_pkg::TBL_IDX_W-1:0];
    assign ch_ok  = (32'(item_ch_reg) < 32'(sma_pkg::NUM_CHANNELS));
    assign e_n    = tot_reg[tidx];
    assign e_idx  = idx_reg[tidx];
    assign e_spos = spos_reg[tidx];
    assign e_epos = epos_reg[tidx];
    assign e_cpos = cpos_reg[tidx];
    assign e_alt  = alt_reg[tidx];

    // Step decision: a move with equal ends jumps to its final step.
    always_comb
    begin
        idle = (e_n == '0);
        if (e_idx == '0 && e_spos == e_epos)
        begin
            si0 = {1'b0, e_n} - IW'(1);
        end
        else
        begin
            si0 = e_idx;
        end
        hold     = {1'b0, e_n} + IW'(catchup_reg);
        interp   = !idle && (si0 < {1'b0, e_n});
        catchup  = !idle && !interp && (si0 < hold);
        finish   = !idle && !interp && !catchup && (si0 == hold) && (e_cpos != '0);
        diff     = {1'b0, e_epos} - {1'b0, e_spos};
        diff_mag = diff[PW] ? PW'(-diff) : diff[PW-1:0];
    end

    // Multiplier and one restoring division step.
    assign product   = ev_step_reg[SW-1:0] * ev_mag_reg;
    assign trial_rem = {rem_reg, dvd_reg[sma_pkg::PROD_W-1]};
    assign trial_sub = trial_rem - {1'b0, ev_n_reg};

    // New position: start plus the signed quotient, kept to the field width.
    assign quot    = dvd_reg[PW-1:0];
    assign pos_new = ev_neg_reg ? (e_spos - quot) : (e_spos + quot);

    assign out_free = !out_valid_reg || out_ready;

    // Move table and catch-up register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            catchup_reg <= sma_pkg::CATCHUP_RESET;
            for (int i = 0; i < sma_pkg::TBL_DEPTH; i++)
            begin
                tot_reg[i]  <= '0;
                idx_reg[i]  <= '0;
                spos_reg[i] <= '0;
                epos_reg[i] <= '0;
                cpos_reg[i] <= '0;
                alt_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                catchup_reg <= cfg_data;
            end
            if (cmd.eval && ch_ok && item_cmd_reg == sma_pkg::CMD_START)
            begin
                spos_reg[tidx] <= item_from_reg;
                epos_reg[tidx] <= item_to_reg;
                tot_reg[tidx]  <= item_steps_reg;
                alt_reg[tidx]  <= item_alt_reg;
                idx_reg[tidx]  <= '0;
            end
            if (cmd.wb)
            begin
                idx_reg[tidx] <= ev_step_reg;
                if (ev_clear_reg)
                begin
                    tot_reg[tidx] <= '0;
                end
                if (ev_strobe_reg)
                begin
                    cpos_reg[tidx] <= pos_new;
                end
            end
        end
    end

    // Input beat capture and step decision registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_cmd_reg   <= in_command;
            item_ch_reg    <= in_channel;
            item_from_reg  <= in_from;
            item_to_reg    <= in_to;
            item_steps_reg <= in_steps;
            item_alt_reg   <= in_alt;
        end
        if (cmd.eval)
        begin
            ev_step_reg   <= (interp || catchup) ? (si0 + IW'(1)) : si0;
            ev_strobe_reg <= interp;
            ev_act_reg    <= !idle && !finish;
            ev_clear_reg  <= finish;
            ev_neg_reg    <= diff[PW];
            ev_mag_reg    <= diff_mag;
            ev_n_reg      <= e_n;
        end
    end

    // Restoring divider: one quotient bit per cycle, shifted into the dividend.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            dvd_reg <= product;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + sma_pkg::CNT_W'(1);
            if (!trial_sub[SW])
            begin
                rem_reg <= trial_sub[SW-1:0];
                dvd_reg <= {dvd_reg[sma_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial_rem[SW-1:0];
                dvd_reg <= {dvd_reg[sma_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.wb)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.wb)
        begin
            out_ch_reg     <= item_ch_reg;
            out_pos_reg    <= ev_strobe_reg ? pos_new : e_cpos;
            out_strobe_reg <= ev_strobe_reg;
            out_alt_reg    <= e_alt;
            out_active_reg <= ev_act_reg;
        end
    end

    // Status to the controller.
    assign status.is_start = (item_cmd_reg == sma_pkg::CMD_START);
    assign status.ch_ok    = ch_ok;
    assign status.interp   = interp;
    assign status.div_last = (cnt_reg == sma_pkg::CNT_W'(sma_pkg::DIV_STEPS - 1));
    assign status.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_ch_reg;
    assign out_position = out_pos_reg;
    assign out_strobe   = out_strobe_reg;
    assign out_alt      = out_alt_reg;
    assign out_active   = out_active_reg;

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A written position always belongs to a running move.
    a_strobe_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_strobe_reg) |-> out_active_reg)
        else $error("strobe on an inactive channel");

endmodule

`default_nettype wire
